@@ hdl/priority_ready_queue_scheduler_core_assert.svh @@
// assertion macros for the ready-queue scheduler
// used by the top level only, taken in by `include
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define PRQS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("prqs: same-cycle check failed");

// next-cycle implication
`define PRQS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("prqs: next-cycle check failed");

`endif

@@ hdl/prqs_pkg.sv @@
// types, sizes and codes for the ready-queue scheduler
// no dependencies; used by every module of the block
package prqs_pkg;

	localparam int PrioLevels = 8;
	localparam int MaxThreads = 16;
	localparam int TidW       = $clog2(MaxThreads);
	localparam int PrioW      = $clog2(PrioLevels);
	localparam int LinkW      = TidW + 1;
	localparam int TickW      = 32;
	localparam int SliceW     = 16;
	localparam int CfgW       = 16;
	localparam int ModeW      = 3;

	typedef logic [TidW-1:0]       tid_t;
	typedef logic [PrioW-1:0]      prio_t;
	typedef logic [LinkW-1:0]      link_t;
	typedef logic [PrioLevels-1:0] map_t;
	typedef logic [MaxThreads-1:0] qflags_t;
	typedef logic [TickW-1:0]      tick_t;
	typedef logic [SliceW-1:0]     slice_t;

	localparam link_t  Nil           = link_t'(MaxThreads);
	localparam tid_t   IdleThread    = tid_t'(1);
	localparam tid_t   BootThread    = tid_t'(0);
	localparam prio_t  LowestPrio    = prio_t'(PrioLevels - 1);
	localparam prio_t  BootPrioReset = prio_t'(3);
	localparam slice_t SliceReset    = slice_t'(10);

	typedef enum logic [ModeW-1:0] {
		ModeInsert  = 3'd0,
		ModeRemove  = 3'd1,
		ModeTick    = 3'd2,
		ModeResched = 3'd3,
		ModeBlock   = 3'd4
	} mode_t;

	typedef enum logic [0:0] {
		RegTimeSlice = 1'b0,
		RegBootPrio  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [ModeW-1:0] mode;
		logic [3:0]       thread_id;
		logic [2:0]       priority_req;
		logic             locked;
	} item_t;

	typedef struct packed {
		logic            we;
		cfg_reg_t        index;
		logic [CfgW-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic       switched;
		logic [3:0] running_id;
		logic [2:0] running_priority;
		logic [7:0] ready_map;
		logic       ignored;
	} result_t;

	typedef struct packed {
		logic cur_queued;
		map_t map;
	} core_status_t;

endpackage

@@ hdl/priority_ready_queue_scheduler_core.sv @@
// top level of the bitmap ready-queue thread scheduler
// depends on prqs_pkg, prqs_queue_core and the assertion macro header
//
// Usage:
//   Events enter on start with mode, thread_id, priority_req and locked. An
//   item is taken at a rising edge with start high and busy low; busy stays
//   low, so an item may be offered in every cycle.
//   Each item gives one result: done is high for one cycle with switched,
//   running_id, running_priority, ready_map and ignored valid alongside.
//   Order: input register, then queue update into the result register.
//   Throughput: one item per cycle; the queue update, priority encode and
//   the tick add and deadline compare all sit in that single stage.
//   The receiver cannot stall: a result is there for its one cycle only.
//   Registers: cfg_we with cfg_index 0 (time_slice) or 1 (boot_priority) and
//   cfg_data, written at the edge; the user must write them only while no
//   item is in flight, which the block itself does not enforce.
//   Reset: thread 0 runs at the boot priority with a zero deadline, idle
//   thread 1 waits alone at the lowest priority, tick count is zero.
`include "priority_ready_queue_scheduler_core_assert.svh"

module priority_ready_queue_scheduler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [3:0]  thread_id,
	input  logic [2:0]  priority_req,
	input  logic        locked,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic        switched,
	output logic [3:0]  running_id,
	output logic [2:0]  running_priority,
	output logic [7:0]  ready_map,
	output logic        ignored
);

	logic                   accept;
	logic                   valid_s1;
	prqs_pkg::item_t        item_s1;
	logic                   done_s2;
	prqs_pkg::result_t      result_s2;
	prqs_pkg::result_t      core_result;
	prqs_pkg::core_status_t core_status;
	prqs_pkg::cfg_wr_t      cfg;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign cfg.we    = cfg_we;
	assign cfg.index = prqs_pkg::cfg_reg_t'(cfg_index);
	assign cfg.data  = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			done_s2  <= valid_s1;
		end
	end

	// payload stages, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.mode         <= mode;
			item_s1.thread_id    <= thread_id;
			item_s1.priority_req <= priority_req;
			item_s1.locked       <= locked;
		end
		if (valid_s1) begin
			result_s2 <= core_result;
		end
	end

	prqs_queue_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.cfg        (cfg),
		.result     (core_result),
		.status     (core_status)
	);

	assign done             = done_s2;
	assign switched         = result_s2.switched;
	assign running_id       = result_s2.running_id;
	assign running_priority = result_s2.running_priority;
	assign ready_map        = result_s2.ready_map;
	assign ignored          = result_s2.ignored;

	// every item in the update stage reports in the next cycle
	`PRQS_ASSERT_NXT(a_item_reports, clk, arst_n, valid_s1, done_s2)
	// a rejected insert or remove never changes the running thread
	`PRQS_ASSERT_IMP(a_ignored_no_switch, clk, arst_n, done_s2 && result_s2.ignored,
		!result_s2.switched)
	// the running thread is never held in a ready queue
	`PRQS_ASSERT_IMP(a_running_not_queued, clk, arst_n, 1'b1, !core_status.cur_queued)
	// the reported map matches the queue state left by that item
	`PRQS_ASSERT_IMP(a_map_matches_state, clk, arst_n, done_s2,
		result_s2.ready_map == core_status.map)

endmodule

@@ hdl/prqs_prio_enc.sv @@
// lowest-set-bit encoder over the non-empty queue map
// depends on prqs_pkg
module prqs_prio_enc (
	input  prqs_pkg::map_t  map,
	output logic            found,
	output prqs_pkg::prio_t idx
);

	always_comb begin
		found = |map;
		idx   = '0;
		// scan downwards so the lowest set bit wins
		for (int i = prqs_pkg::PrioLevels - 1; i >= 0; i--) begin
			if (map[i]) begin
				idx = prqs_pkg::prio_t'(i);
			end
		end
	end

endmodule

@@ hdl/prqs_queue_core.sv @@
// scheduler state: linked ready queues, running thread, tick and deadline
// depends on prqs_pkg and prqs_prio_enc; one item is applied per cycle
module prqs_queue_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  prqs_pkg::item_t        item,
	input  prqs_pkg::cfg_wr_t      cfg,
	output prqs_pkg::result_t      result,
	output prqs_pkg::core_status_t status
);

	prqs_pkg::link_t   next_q  [prqs_pkg::MaxThreads];
	prqs_pkg::link_t   prev_q  [prqs_pkg::MaxThreads];
	prqs_pkg::prio_t   tprio_q [prqs_pkg::MaxThreads];
	prqs_pkg::link_t   head_q  [prqs_pkg::PrioLevels];
	prqs_pkg::link_t   tail_q  [prqs_pkg::PrioLevels];
	prqs_pkg::qflags_t queued_q;
	prqs_pkg::map_t    map_q;
	prqs_pkg::tid_t    cur_q;
	prqs_pkg::prio_t   cur_prio_q;
	prqs_pkg::tick_t   deadline_q;
	prqs_pkg::tick_t   tick_q;
	prqs_pkg::slice_t  slice_q;

	prqs_pkg::link_t   next_d  [prqs_pkg::MaxThreads];
	prqs_pkg::link_t   prev_d  [prqs_pkg::MaxThreads];
	prqs_pkg::prio_t   tprio_d [prqs_pkg::MaxThreads];
	prqs_pkg::link_t   head_d  [prqs_pkg::PrioLevels];
	prqs_pkg::link_t   tail_d  [prqs_pkg::PrioLevels];
	prqs_pkg::qflags_t queued_d;
	prqs_pkg::map_t    map_d;
	prqs_pkg::tid_t    cur_d;
	prqs_pkg::prio_t   cur_prio_d;
	prqs_pkg::tick_t   deadline_d;
	prqs_pkg::tick_t   tick_d;
	prqs_pkg::slice_t  slice_d;

	logic            best_found;
	prqs_pkg::prio_t best_idx;

	prqs_prio_enc u_prio_enc (
		.map   (map_q),
		.found (best_found),
		.idx   (best_idx)
	);

	always_comb begin
		logic            ignored;
		logic            do_enq;
		logic            do_unl;
		logic            take_head;
		logic            eligible;
		prqs_pkg::tid_t  tid;
		prqs_pkg::tid_t  enq_t;
		prqs_pkg::prio_t enq_p;
		prqs_pkg::tid_t  unl_t;
		prqs_pkg::prio_t unl_p;
		prqs_pkg::link_t tail_v;
		prqs_pkg::link_t nxt_v;
		prqs_pkg::link_t prv_v;
		prqs_pkg::tick_t t_now;
		prqs_pkg::tick_t fresh_dl;
		prqs_pkg::prio_t boot_p;

		next_d     = next_q;
		prev_d     = prev_q;
		tprio_d    = tprio_q;
		head_d     = head_q;
		tail_d     = tail_q;
		queued_d   = queued_q;
		map_d      = map_q;
		cur_d      = cur_q;
		cur_prio_d = cur_prio_q;
		deadline_d = deadline_q;
		tick_d     = tick_q;
		slice_d    = slice_q;

		ignored   = 1'b0;
		do_enq    = 1'b0;
		do_unl    = 1'b0;
		take_head = 1'b0;
		tid       = prqs_pkg::tid_t'(item.thread_id);
		enq_t     = tid;
		enq_p     = prqs_pkg::prio_t'(item.priority_req);
		unl_t     = tid;
		unl_p     = tprio_q[tid];
		tail_v    = prqs_pkg::Nil;
		nxt_v     = prqs_pkg::Nil;
		prv_v     = prqs_pkg::Nil;
		boot_p    = prqs_pkg::LowestPrio;
		eligible  = best_found && (best_idx <= cur_prio_q);

		if (item_valid && item.mode == prqs_pkg::ModeTick) begin
			t_now = tick_q + prqs_pkg::tick_t'(1);
		end else begin
			t_now = tick_q;
		end
		fresh_dl = t_now + {{(prqs_pkg::TickW - prqs_pkg::SliceW){1'b0}}, slice_q};

		if (item_valid) begin
			case (item.mode)
				prqs_pkg::ModeInsert: begin
					if (int'(item.priority_req) >= prqs_pkg::PrioLevels || queued_q[tid]
							|| tid == cur_q) begin
						ignored = 1'b1;
					end else begin
						do_enq = 1'b1;
					end
				end
				prqs_pkg::ModeRemove: begin
					if (!queued_q[tid] || tid == cur_q) begin
						ignored = 1'b1;
					end else begin
						do_unl = 1'b1;
					end
				end
				prqs_pkg::ModeTick, prqs_pkg::ModeResched: begin
					tick_d = t_now;
					if (!item.locked && t_now >= deadline_q) begin
						if (eligible) begin
							// running thread back to its tail, best head switched in
							do_enq    = 1'b1;
							enq_t     = cur_q;
							enq_p     = cur_prio_q;
							take_head = 1'b1;
						end else if (item.mode == prqs_pkg::ModeResched) begin
							deadline_d = fresh_dl;
						end
					end
				end
				prqs_pkg::ModeBlock: begin
					take_head = best_found;
				end
				default: begin
				end
			endcase
		end

		if (take_head) begin
			// best queue is non-empty, so its head is unchanged by the requeue
			do_unl     = 1'b1;
			unl_t      = head_q[best_idx][prqs_pkg::TidW-1:0];
			unl_p      = best_idx;
			cur_d      = unl_t;
			cur_prio_d = best_idx;
			deadline_d = fresh_dl;
		end

		if (do_enq) begin
			tail_v         = tail_d[enq_p];
			tprio_d[enq_t] = enq_p;
			prev_d[enq_t]  = tail_v;
			next_d[enq_t]  = prqs_pkg::Nil;
			if (tail_v == prqs_pkg::Nil) begin
				head_d[enq_p] = {1'b0, enq_t};
			end else begin
				next_d[tail_v[prqs_pkg::TidW-1:0]] = {1'b0, enq_t};
			end
			tail_d[enq_p]   = {1'b0, enq_t};
			queued_d[enq_t] = 1'b1;
			map_d[enq_p]    = 1'b1;
		end

		if (do_unl) begin
			nxt_v = next_d[unl_t];
			prv_v = prev_d[unl_t];
			if (prv_v == prqs_pkg::Nil) begin
				head_d[unl_p] = nxt_v;
			end else begin
				next_d[prv_v[prqs_pkg::TidW-1:0]] = nxt_v;
			end
			if (nxt_v == prqs_pkg::Nil) begin
				tail_d[unl_p] = prv_v;
			end else begin
				prev_d[nxt_v[prqs_pkg::TidW-1:0]] = prv_v;
			end
			next_d[unl_t]   = prqs_pkg::Nil;
			prev_d[unl_t]   = prqs_pkg::Nil;
			queued_d[unl_t] = 1'b0;
			if (head_d[unl_p] == prqs_pkg::Nil) begin
				map_d[unl_p] = 1'b0;
			end
		end

		// the user must send register writes only while no item is in flight; the block does not enforce this
		if (cfg.we) begin
			unique case (cfg.index)
				prqs_pkg::RegTimeSlice: begin
					slice_d = cfg.data[prqs_pkg::SliceW-1:0];
				end
				prqs_pkg::RegBootPrio: begin
					if (int'(cfg.data[2:0]) < prqs_pkg::PrioLevels) begin
						boot_p = prqs_pkg::prio_t'(cfg.data[2:0]);
					end
					if (!queued_q[prqs_pkg::BootThread]) begin
						tprio_d[prqs_pkg::BootThread] = boot_p;
						if (cur_q == prqs_pkg::BootThread) begin
							cur_prio_d = boot_p;
						end
					end
				end
			endcase
		end

		result.switched         = (cur_d != cur_q);
		result.running_id       = 4'(cur_d);
		result.running_priority = 3'(cur_prio_d);
		result.ready_map        = 8'(map_d);
		result.ignored          = ignored;
	end

	assign status.cur_queued = queued_q[cur_q];
	assign status.map        = map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < prqs_pkg::MaxThreads; i++) begin
				next_q[i] <= prqs_pkg::Nil;
				prev_q[i] <= prqs_pkg::Nil;
				if (i == int'(prqs_pkg::BootThread)) begin
					tprio_q[i] <= prqs_pkg::BootPrioReset;
				end else if (i == int'(prqs_pkg::IdleThread)) begin
					tprio_q[i] <= prqs_pkg::LowestPrio;
				end else begin
					tprio_q[i] <= '0;
				end
			end
			for (int i = 0; i < prqs_pkg::PrioLevels; i++) begin
				if (i == int'(prqs_pkg::LowestPrio)) begin
					head_q[i] <= {1'b0, prqs_pkg::IdleThread};
					tail_q[i] <= {1'b0, prqs_pkg::IdleThread};
				end else begin
					head_q[i] <= prqs_pkg::Nil;
					tail_q[i] <= prqs_pkg::Nil;
				end
			end
			queued_q   <= prqs_pkg::qflags_t'(1) << prqs_pkg::IdleThread;
			map_q      <= prqs_pkg::map_t'(1) << prqs_pkg::LowestPrio;
			cur_q      <= prqs_pkg::BootThread;
			cur_prio_q <= prqs_pkg::BootPrioReset;
			deadline_q <= '0;
			tick_q     <= '0;
			slice_q    <= prqs_pkg::SliceReset;
		end else begin
			next_q     <= next_d;
			prev_q     <= prev_d;
			tprio_q    <= tprio_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			queued_q   <= queued_d;
			map_q      <= map_d;
			cur_q      <= cur_d;
			cur_prio_q <= cur_prio_d;
			deadline_q <= deadline_d;
			tick_q     <= tick_d;
			slice_q    <= slice_d;
		end
	end

endmodule
